>>> hdl/stp_pkg.sv
// ---------------------------------------------------------------------------
// Stepper positioner package
// Types, codes and constants shared by the step/direction positioner and its
// port checker.
// ---------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

    // Kind of an input word, carried on the slave-side tuser.
    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_SET_GOAL = 2'd1,
        MODE_HOME     = 2'd2,
        MODE_BUTTON   = 2'd3
    } t_mode;

    // Status code reported in every result word.
    typedef enum logic [1:0] {
        STATUS_DONE   = 2'd0,
        STATUS_MOVING = 2'd1,
        STATUS_HOMING = 2'd2
    } t_status;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STEPS_PER_MM  = 2'd0;
    localparam logic [1:0] CFG_MEDIUM_MOVE   = 2'd1;
    localparam logic [1:0] CFG_LARGE_MOVE    = 2'd2;

    localparam int SPM_W   = 16;
    localparam int MM_W    = 8;
    localparam int JOG_W   = SPM_W + MM_W;
    localparam int POS_W   = 32;

    localparam logic [SPM_W-1:0] SPM_RESET    = 16'd1600;
    localparam logic [MM_W-1:0]  MEDIUM_RESET = 8'd5;
    localparam logic [MM_W-1:0]  LARGE_RESET  = 8'd50;
    localparam logic [JOG_W-1:0] MEDIUM_STEPS_RESET = 24'd8000;
    localparam logic [JOG_W-1:0] LARGE_STEPS_RESET  = 24'd80000;

    // Resistor ladder thresholds, lowest button first.
    localparam logic [POS_W-1:0] LADDER_LARGE_DOWN  = 32'd75;
    localparam logic [POS_W-1:0] LADDER_MEDIUM_DOWN = 32'd225;
    localparam logic [POS_W-1:0] LADDER_MM_DOWN     = 32'd350;
    localparam logic [POS_W-1:0] LADDER_STOP        = 32'd475;
    localparam logic [POS_W-1:0] LADDER_MM_UP       = 32'd590;
    localparam logic [POS_W-1:0] LADDER_MEDIUM_UP   = 32'd690;
    localparam logic [POS_W-1:0] LADDER_LARGE_UP    = 32'd790;

    // Result and input word widths.
    localparam int OUT_DATA_W = 72;
    localparam int IN_DATA_W  = 40;

endpackage

`default_nettype wire

>>> hdl/stepper_step_dir_positioner.sv
// ---------------------------------------------------------------------------
// Stepper step/direction positioner
// Step pulse and direction generator with homing and ladder-button jogging.
// ---------------------------------------------------------------------------
// Datapath: an accepted word is registered in the input register, then processed
// into the result register once that register is empty or being drained.
// Throughput: one word per cycle while the result side keeps tready high; the
// state update of one word is a single compare and add into the registers.
// Reset: synchronous, active low; motion state clears to zero and the jog
// registers return to 1600 steps/mm, 5 mm and 50 mm. No clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module stepper_step_dir_positioner
    import stp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Configuration write channel.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [SPM_W-1:0]      i_cfg_data,

    // Input words.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata, lowest bit up: value[31:0], end_switch[32], zero pad [39:33].
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: mode[1:0].
    input  wire logic [1:0]            s_axis_tuser,

    // Result words.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata, lowest bit up: step_level[0], direction[1], done_flag[2],
    // status[4:3], position[36:5], goal[68:37], running[69], zero pad [71:70].
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    // ------------------------------------------------------------------
    // Configuration. The jog distances in steps are kept as products so
    // that the item path never has to multiply; each product is refreshed
    // in the same write that changes one of its factors.
    // ------------------------------------------------------------------
    logic [SPM_W-1:0] r_spm;
    logic [MM_W-1:0]  r_medium_mm;
    logic [MM_W-1:0]  r_large_mm;
    logic [JOG_W-1:0] r_medium_steps;
    logic [JOG_W-1:0] r_large_steps;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm          <= SPM_RESET;
            r_medium_mm    <= MEDIUM_RESET;
            r_large_mm     <= LARGE_RESET;
            r_medium_steps <= MEDIUM_STEPS_RESET;
            r_large_steps  <= LARGE_STEPS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEPS_PER_MM: begin
                    r_spm          <= i_cfg_data;
                    r_medium_steps <= JOG_W'(i_cfg_data) * JOG_W'(r_medium_mm);
                    r_large_steps  <= JOG_W'(i_cfg_data) * JOG_W'(r_large_mm);
                end
                CFG_MEDIUM_MOVE: begin
                    r_medium_mm    <= i_cfg_data[MM_W-1:0];
                    r_medium_steps <= JOG_W'(r_spm) * JOG_W'(i_cfg_data[MM_W-1:0]);
                end
                CFG_LARGE_MOVE: begin
                    r_large_mm     <= i_cfg_data[MM_W-1:0];
                    r_large_steps  <= JOG_W'(r_spm) * JOG_W'(i_cfg_data[MM_W-1:0]);
                end
                default: begin
                    // Indexes beyond the register list are dropped.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input register takes a word whenever it is empty or
    // is being processed this cycle; processing goes ahead whenever the
    // result register is empty or being drained. So one finished result
    // may wait downstream while the next word is already held here.
    // ------------------------------------------------------------------
    logic r_in_valid;
    logic r_out_valid;
    logic w_out_free;
    logic w_proc;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_proc        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    t_mode             r_in_mode;
    logic [POS_W-1:0]  r_in_value;
    logic              r_in_switch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_mode   <= t_mode'(s_axis_tuser);
            r_in_value  <= s_axis_tdata[POS_W-1:0];
            r_in_switch <= s_axis_tdata[POS_W];
        end
    end

    // ------------------------------------------------------------------
    // Motion state.
    // ------------------------------------------------------------------
    logic [POS_W-1:0] r_goal,     n_goal;
    logic [POS_W-1:0] r_position, n_position;
    logic             r_done,     n_done;
    logic             r_homing,   n_homing;
    logic             r_pulse,    n_pulse;
    logic             r_running,  n_running;
    logic             r_dir,      n_dir;

    // Button decode: a jog magnitude in steps and a sign. The stop band
    // asks for the goal to become the current position.
    logic             w_jog_req;
    logic             w_jog_up;
    logic [JOG_W-1:0] w_jog_mag;
    logic [POS_W-1:0] w_jog_goal;

    always_comb begin
        w_jog_req = 1'b1;
        w_jog_up  = 1'b0;
        w_jog_mag = '0;
        if (r_in_value < LADDER_LARGE_DOWN) begin
            w_jog_mag = r_large_steps;
        end else if (r_in_value < LADDER_MEDIUM_DOWN) begin
            w_jog_mag = r_medium_steps;
        end else if (r_in_value < LADDER_MM_DOWN) begin
            w_jog_mag = {{MM_W{1'b0}}, r_spm};
        end else if (r_in_value < LADDER_STOP) begin
            w_jog_mag = '0;
        end else if (r_in_value < LADDER_MM_UP) begin
            w_jog_up  = 1'b1;
            w_jog_mag = {{MM_W{1'b0}}, r_spm};
        end else if (r_in_value < LADDER_MEDIUM_UP) begin
            w_jog_up  = 1'b1;
            w_jog_mag = r_medium_steps;
        end else if (r_in_value < LADDER_LARGE_UP) begin
            w_jog_up  = 1'b1;
            w_jog_mag = r_large_steps;
        end else begin
            // Top of the ladder, and negative values read as large
            // unsigned numbers: no button pressed.
            w_jog_req = 1'b0;
        end
    end

    assign w_jog_goal = w_jog_up
                      ? r_position + {{(POS_W-JOG_W){1'b0}}, w_jog_mag}
                      : r_position - {{(POS_W-JOG_W){1'b0}}, w_jog_mag};

    // A goal write only counts when it changes the goal; it then clears
    // done and starts the tick timer, homing or not.
    logic             w_goal_req;
    logic [POS_W-1:0] w_goal_val;

    always_comb begin
        w_goal_req = 1'b0;
        w_goal_val = r_in_value;
        if (r_in_mode == MODE_SET_GOAL) begin
            w_goal_req = 1'b1;
        end else if (r_in_mode == MODE_BUTTON) begin
            w_goal_req = w_jog_req;
            w_goal_val = w_jog_goal;
        end
    end

    always_comb begin
        n_goal     = r_goal;
        n_position = r_position;
        n_done     = r_done;
        n_homing   = r_homing;
        n_pulse    = r_pulse;
        n_running  = r_running;
        n_dir      = r_dir;
        case (r_in_mode)
            MODE_TICK: begin
                if (r_running) begin
                    if (r_homing) begin
                        // Homing pushes until the switch is seen on a
                        // high step level, then zeroes the axis.
                        if (r_pulse) begin
                            if (r_in_switch) begin
                                n_goal     = '0;
                                n_position = '0;
                                n_homing   = 1'b0;
                                n_running  = 1'b0;
                            end
                            n_pulse = 1'b0;
                        end else begin
                            n_dir   = 1'b1;
                            n_pulse = 1'b1;
                        end
                    end else if (r_pulse) begin
                        if (r_goal == r_position) begin
                            // Target reached with the step level high.
                            n_running = 1'b0;
                            n_done    = 1'b1;
                        end else begin
                            n_pulse = 1'b0;
                        end
                    end else begin
                        // Rising edge: step toward the goal. Equal counts
                        // as not above, so the position dips by one.
                        if ($signed(r_goal) > $signed(r_position)) begin
                            n_dir      = 1'b0;
                            n_position = r_position + 32'd1;
                        end else begin
                            n_dir      = 1'b1;
                            n_position = r_position - 32'd1;
                        end
                        n_pulse = 1'b1;
                    end
                end
            end
            MODE_HOME: begin
                n_homing  = 1'b1;
                n_running = 1'b1;
            end
            default: begin
                if (w_goal_req && (w_goal_val != r_goal)) begin
                    n_goal    = w_goal_val;
                    n_done    = 1'b0;
                    n_running = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal     <= '0;
            r_position <= '0;
            r_done     <= 1'b0;
            r_homing   <= 1'b0;
            r_pulse    <= 1'b0;
            r_running  <= 1'b0;
            r_dir      <= 1'b0;
        end else if (w_proc) begin
            r_goal     <= n_goal;
            r_position <= n_position;
            r_done     <= n_done;
            r_homing   <= n_homing;
            r_pulse    <= n_pulse;
            r_running  <= n_running;
            r_dir      <= n_dir;
        end
    end

    // ------------------------------------------------------------------
    // Result register, loaded with the state as it stands after the word.
    // ------------------------------------------------------------------
    t_status                 w_status;
    logic [OUT_DATA_W-1:0]   r_out_data;

    always_comb begin
        if (n_homing) begin
            w_status = STATUS_HOMING;
        end else if (n_done) begin
            w_status = STATUS_DONE;
        end else begin
            w_status = STATUS_MOVING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_data <= {2'b00, n_running, n_goal, n_position, w_status,
                           n_done, n_dir, n_pulse};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> hdl/stp_port_checker.sv
// ---------------------------------------------------------------------------
// Stepper positioner port checker
// Assertions on the result stream of the positioner, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

module stp_port_checker
    import stp_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [1:0]       w_status;
    logic             w_done;
    logic             w_running;
    logic [POS_W-1:0] w_position;
    logic [POS_W-1:0] w_goal;

    assign w_done     = m_axis_tdata[2];
    assign w_status   = m_axis_tdata[4:3];
    assign w_position = m_axis_tdata[36:5];
    assign w_goal     = m_axis_tdata[68:37];
    assign w_running  = m_axis_tdata[69];

    // A stalled result word holds still.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Outside homing the status code follows the done flag.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status != STATUS_HOMING)
        |-> (w_done == (w_status == STATUS_DONE)))
        else $error("status disagrees with done flag");

    // Done outside homing means the axis sits on its goal with the timer off.
    a_done_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == STATUS_DONE)
        |-> (w_position == w_goal) && !w_running)
        else $error("done reported away from goal or while running");

    // Homing always keeps the tick timer going.
    a_homing_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == STATUS_HOMING) |-> w_running)
        else $error("homing with the timer stopped");

endmodule

bind stepper_step_dir_positioner stp_port_checker u_stp_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Step/direction positioner testbench
// Drives ticks, absolute targets, homing requests and ladder-button readings
// into the positioner and checks every result word against a cycle-free
// predictor of the motion state. The jog registers are rewritten between
// phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_top;
    import stp_pkg::*;

    // One expected result word, unpacked into its fields.
    typedef struct {
        logic             step_level;
        logic             direction;
        logic             done_flag;
        t_status          status;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] goal;
        logic             running;
    } t_motion_word;

    // Predictor of the motion state plus the queue of result words it has
    // worked out but not yet seen on the master side.
    class t_motion_tracker;
        logic [SPM_W-1:0] steps_per_mm;
        logic [MM_W-1:0]  medium_mm;
        logic [MM_W-1:0]  large_mm;
        logic [POS_W-1:0] goal;
        logic [POS_W-1:0] position;
        logic             done;
        logic             homing;
        logic             pulse;
        logic             running;
        logic             direction;
        t_motion_word     awaited[$];
        int               mismatches;

        function new();
            steps_per_mm = SPM_RESET;
            medium_mm    = MEDIUM_RESET;
            large_mm     = LARGE_RESET;
            goal         = '0;
            position     = '0;
            done         = 1'b0;
            homing       = 1'b0;
            pulse        = 1'b0;
            running      = 1'b0;
            direction    = 1'b0;
            mismatches   = 0;
        endfunction

        function void write_register(logic [1:0] index, logic [SPM_W-1:0] data);
            case (index)
                CFG_STEPS_PER_MM: steps_per_mm = data;
                CFG_MEDIUM_MOVE:  medium_mm    = data[MM_W-1:0];
                CFG_LARGE_MOVE:   large_mm     = data[MM_W-1:0];
                default: ;
            endcase
        endfunction

        // A new target only takes effect when it differs from the current one.
        function void retarget(logic [POS_W-1:0] target);
            if (target != goal) begin
                goal    = target;
                done    = 1'b0;
                running = 1'b1;
            end
        endfunction

        function void half_period(logic end_switch);
            if (!running)
                return;
            if (homing) begin
                if (pulse) begin
                    // The end switch only counts while the step level is high.
                    if (end_switch) begin
                        goal     = '0;
                        position = '0;
                        homing   = 1'b0;
                        running  = 1'b0;
                    end
                    pulse = 1'b0;
                end else begin
                    direction = 1'b1;
                    pulse     = 1'b1;
                end
            end else if (pulse) begin
                if (goal == position) begin
                    running = 1'b0;
                    done    = 1'b1;
                end else begin
                    pulse = 1'b0;
                end
            end else begin
                // Equal goal and position counts as not above: step down.
                if ($signed(goal) > $signed(position)) begin
                    direction = 1'b0;
                    position  = position + 32'd1;
                end else begin
                    direction = 1'b1;
                    position  = position - 32'd1;
                end
                pulse = 1'b1;
            end
        endfunction

        function void jog(logic [POS_W-1:0] reading);
            logic [POS_W-1:0] unit;
            logic [POS_W-1:0] medium_steps;
            logic [POS_W-1:0] large_steps;
            unit         = {16'd0, steps_per_mm};
            medium_steps = unit * {24'd0, medium_mm};
            large_steps  = unit * {24'd0, large_mm};
            if (reading < LADDER_LARGE_DOWN)
                retarget(position - large_steps);
            else if (reading < LADDER_MEDIUM_DOWN)
                retarget(position - medium_steps);
            else if (reading < LADDER_MM_DOWN)
                retarget(position - unit);
            else if (reading < LADDER_STOP)
                retarget(position);
            else if (reading < LADDER_MM_UP)
                retarget(position + unit);
            else if (reading < LADDER_MEDIUM_UP)
                retarget(position + medium_steps);
            else if (reading < LADDER_LARGE_UP)
                retarget(position + large_steps);
        endfunction

        function void note_word(t_mode mode, logic [POS_W-1:0] value, logic end_switch);
            t_motion_word w;
            case (mode)
                MODE_TICK:     half_period(end_switch);
                MODE_SET_GOAL: retarget(value);
                MODE_HOME: begin
                    homing  = 1'b1;
                    running = 1'b1;
                end
                default:       jog(value);
            endcase
            w.step_level = pulse;
            w.direction  = direction;
            w.done_flag  = done;
            w.status     = homing ? STATUS_HOMING : (done ? STATUS_DONE : STATUS_MOVING);
            w.position   = position;
            w.goal       = goal;
            w.running    = running;
            awaited.push_back(w);
        endfunction

        function void compare(string name, logic [POS_W-1:0] expected, logic [POS_W-1:0] actual);
            if (expected !== actual) begin
                $error("%s: expected %0h, got %0h", name, expected, actual);
                mismatches++;
            end
        endfunction

        function void check_word(logic [OUT_DATA_W-1:0] data);
            t_motion_word w;
            if (awaited.size() == 0) begin
                $error("result word %0h arrived with nothing awaited", data);
                mismatches++;
                return;
            end
            w = awaited.pop_front();
            compare("step_level", w.step_level, data[0]);
            compare("direction", w.direction, data[1]);
            compare("done_flag", w.done_flag, data[2]);
            compare("status", w.status, data[4:3]);
            compare("position", w.position, data[36:5]);
            compare("goal", w.goal, data[68:37]);
            compare("running", w.running, data[69]);
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Signals. Every input of the block holds a known value from time zero.
    // -----------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index = '0;
    logic [SPM_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata, lowest bit up: value[31:0], end_switch[32], zero pad [39:33].
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // tuser: mode[1:0].
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata, lowest bit up: step_level[0], direction[1], done_flag[2],
    // status[4:3], position[36:5], goal[68:37], running[69], zero pad [71:70].
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Chance in percent that the sender pauses after a word, and percentage of
    // cycles in which the receiver stalls; set anew in the first three phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    t_motion_tracker tracker = new();

    stepper_step_dir_positioner DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns clock period.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs, far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side. The handshake is sampled at the edge, before any of this
    // edge's updates land, so the order of processes in the time step does
    // not matter. The ready level for the next cycle is drawn afresh each
    // cycle, which puts stalls on every phase of the block's work.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_word(m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Offers one input word and holds it until the block takes it. The
    // predictor is told about the word at the edge where it was accepted.
    // A random gap may follow, in which valid goes low.
    task automatic send_word(t_mode mode, logic [POS_W-1:0] value, logic end_switch);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {7'd0, end_switch, value};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_word(mode, value, end_switch);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // One register write on the configuration channel. Valid is then dropped
    // before the next write so that it never falls and rises in the same step.
    task automatic write_register(logic [1:0] index, logic [SPM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_register(index, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stops offering words and waits for every awaited result word, then
    // idles before the next phase.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.awaited.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    // One random word. Most are ticks so that moves run to completion; new
    // targets mostly land a few steps from the current position so that done
    // is reached often, with some full-range targets and repeats of the
    // current goal. Ticks while the motor is stopped do nothing and are not
    // counted.
    task automatic send_random_word(output bit counted);
        int               pick;
        t_mode            mode;
        logic [POS_W-1:0] value;
        logic             end_switch;
        pick       = $urandom_range(0, 99);
        value      = $urandom;
        end_switch = ($urandom_range(0, 5) == 0);
        if (pick < 64) begin
            mode = MODE_TICK;
        end else if (pick < 80) begin
            mode = MODE_SET_GOAL;
            case ($urandom_range(0, 7))
                0:       value = tracker.goal;
                1:       ;
                default: value = tracker.position + $urandom_range(0, 48) - 24;
            endcase
        end else if (pick < 84) begin
            mode = MODE_HOME;
        end else begin
            mode = MODE_BUTTON;
            // Mostly real ladder readings; the rest covers the whole field.
            if ($urandom_range(0, 4) != 0)
                value = $urandom_range(0, 1023);
        end
        counted = !(mode == MODE_TICK && !tracker.running);
        send_word(mode, value, end_switch);
    endtask

    // -----------------------------------------------------------------------
    // Main sequence: reset, four phases with different jog settings, idling
    // patterns set in the first three, then the final verdict.
    // -----------------------------------------------------------------------
    initial begin
        int  phase;
        int  sent;
        bit  counted;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 34;
                    recv_idle_pct = 58;
                    // An index beyond the register list must be ignored.
                    write_register(2'd3, 16'($urandom));
                end
                1: begin
                    send_idle_pct = 58;
                    recv_idle_pct = 34;
                    write_register(CFG_STEPS_PER_MM, 16'hFFFF);
                    write_register(CFG_MEDIUM_MOVE, 16'h00FF);
                    write_register(CFG_LARGE_MOVE, 16'hFFFF);
                end
                2: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // Upper bits of the 8-bit registers are junk and dropped.
                    write_register(CFG_STEPS_PER_MM, 16'd1);
                    write_register(CFG_MEDIUM_MOVE, 16'hA501);
                    write_register(CFG_LARGE_MOVE, 16'd1);
                    write_register(2'd3, 16'($urandom));
                end
                default: begin
                    write_register(CFG_STEPS_PER_MM, 16'($urandom_range(1, 65535)));
                    write_register(CFG_MEDIUM_MOVE, 16'($urandom_range(1, 255)));
                    write_register(CFG_LARGE_MOVE, 16'($urandom_range(1, 255)));
                end
            endcase

            if (phase == 0) begin
                // Directed words with the reset jog settings.
                send_word(MODE_TICK, 32'd0, 1'b1);           // tick while stopped
                send_word(MODE_SET_GOAL, 32'd2, 1'b0);
                repeat (4) send_word(MODE_TICK, 32'd0, 1'b0); // runs to done at 2
                send_word(MODE_SET_GOAL, 32'd2, 1'b0);       // unchanged target
                send_word(MODE_SET_GOAL, 32'h7FFF_FFFF, 1'b0);
                repeat (2) send_word(MODE_TICK, 32'd0, 1'b0);
                send_word(MODE_BUTTON, 32'd400, 1'b0);       // stop at high level
                send_word(MODE_TICK, 32'd0, 1'b0);
                send_word(MODE_SET_GOAL, 32'h8000_0000, 1'b0);
                send_word(MODE_TICK, 32'd0, 1'b0);
                // Stop with the step level low: the next rising edge sees goal
                // equal to position and steps down.
                send_word(MODE_BUTTON, 32'd474, 1'b0);
                send_word(MODE_TICK, 32'd0, 1'b0);
                send_word(MODE_HOME, 32'd0, 1'b0);
                send_word(MODE_TICK, 32'd0, 1'b0);
                send_word(MODE_TICK, 32'd0, 1'b1);           // switch ignored at low
                send_word(MODE_TICK, 32'd0, 1'b1);           // homing ends
                send_word(MODE_BUTTON, 32'd0, 1'b0);
                send_word(MODE_BUTTON, 32'd589, 1'b0);
                send_word(MODE_BUTTON, 32'd789, 1'b0);
                send_word(MODE_BUTTON, 32'd790, 1'b0);       // above the ladder
                send_word(MODE_BUTTON, 32'hFFFF_FFFF, 1'b0); // negative reading
                send_word(MODE_BUTTON, 32'd224, 1'b0);
                send_word(MODE_BUTTON, 32'd349, 1'b0);
                send_word(MODE_BUTTON, 32'd689, 1'b0);
            end

            sent = 0;
            while (sent < 290) begin
                send_random_word(counted);
                if (counted)
                    sent++;
            end
            drain();
        end

        if (tracker.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
